// File: rtl/cabf_pkg.sv
// shared types and constants for the cpu affinity bitmap finder
// no dependencies; imported by the controller, the datapath and the top level
package cabf_pkg;

	localparam int CABF_MAP_WORDS = 4;
	localparam int WORD_BITS      = 64;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 9;

	// item modes
	localparam logic [2:0] MODE_SET       = 3'd0;
	localparam logic [2:0] MODE_CLEAR     = 3'd1;
	localparam logic [2:0] MODE_TEST      = 3'd2;
	localparam logic [2:0] MODE_FIND_HI   = 3'd3;
	localparam logic [2:0] MODE_FIND_LO   = 3'd4;
	localparam logic [2:0] MODE_SET_ALL   = 3'd5;
	localparam logic [2:0] MODE_CLEAR_ALL = 3'd6;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INSTALLED_CPUS = 1'd1;

	localparam logic [2:0] BLOCK_COUNT_RST    = 3'd4;
	localparam logic [8:0] INSTALLED_CPUS_RST = 9'd256;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] cpu_index;
	} in_item_t;

	typedef struct packed {
		logic [7:0] result_index;
		logic       flag;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // take the input item
		logic rd;         // read the word at the pointer
		logic bit_wr;     // modify or test the word just read
		logic find_step;  // evaluate the word just read, advance
		logic fill;       // write one fill word, advance
		logic publish;    // move the result to the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic go_bit;     // item is a set, clear or test inside the map
		logic go_find;    // item is a search on a non-empty map
		logic go_fill;    // item is set-all or clear-all on a non-empty map
		logic hit;        // masked word has a set bit
		logic exhausted;  // search ran out of words
		logic fill_last;  // pointer is at the last word in use
		logic out_free;   // output register can take a result
	} stat_t;

endpackage

// File: rtl/cpu_affinity_bitmap_finder.sv
// top level of the cpu affinity bitmap finder
// depends on cabf_pkg, cabf_ctrl and cabf_dp
//
//  channel | signals                            | moves
//  --------+------------------------------------+-------------------------------
//  cfg     | cfg_we, cfg_index, cfg_data        | register write, no wait
//  in      | in_valid, in_ready, in_item        | one item: mode, cpu_index
//  out     | out_valid, out_ready, out_item     | one item: result_index, flag
//
// one item at a time through a controller and a one-port bitmap store:
//   set, clear, test inside the map: accept, read, modify, publish
//   find: accept, a read and an evaluate per word visited (at most 2 * n), publish
//   set-all, clear-all: accept, fill each word in use, publish; others accept, publish
// every word visit is a store read followed by an evaluate step
// reset clears the per-word valid bits at once, so the map reads as zero with no sweep
// in_ready is high whenever the controller is idle, even while a result waits;
// a stalled result holds the next item at its final step
module cpu_affinity_bitmap_finder
	import cabf_pkg::*;
#(
	parameter int MAP_WORDS = CABF_MAP_WORDS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_item
);

	cmd_t  cmd;
	stat_t stat;

	// sequencing: accept, word reads, search steps, fill sweep, publish
	cabf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// store, config registers, search pointer, encoders and output register
	cabf_dp #(
		.MAP_WORDS (MAP_WORDS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.out_item  (out_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

// File: rtl/cabf_ctrl.sv
// sequencer for the cpu affinity bitmap finder
// depends on cabf_pkg (cmd_t, stat_t)
module cabf_ctrl
	import cabf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_BIT_RD  = 7'b0000010,
		S_BIT_WR  = 7'b0000100,
		S_FIND_RD = 7'b0001000,
		S_FIND_EV = 7'b0010000,
		S_FILL    = 7'b0100000,
		S_DONE    = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (stat.go_bit)       state_d = S_BIT_RD;
					else if (stat.go_find) state_d = S_FIND_RD;
					else if (stat.go_fill) state_d = S_FILL;
					else                   state_d = S_DONE;
				end
			end
			S_BIT_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_BIT_WR;
			end
			S_BIT_WR: begin
				cmd.bit_wr = 1'b1;
				state_d    = S_DONE;
			end
			S_FIND_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_FIND_EV;
			end
			S_FIND_EV: begin
				cmd.find_step = 1'b1;
				if (stat.hit || stat.exhausted) state_d = S_DONE;
				else                            state_d = S_FIND_RD;
			end
			S_FILL: begin
				cmd.fill = 1'b1;
				if (stat.fill_last) state_d = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

endmodule

// File: rtl/cabf_dp.sv
// datapath: bitmap store, config registers, search pointer, encoders, output register
// depends on cabf_pkg (item structs, cmd_t, stat_t, mode and register codes)
module cabf_dp
	import cabf_pkg::*;
#(
	parameter int MAP_WORDS = CABF_MAP_WORDS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  in_item_t              in_item,
	output out_item_t             out_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  cmd_t                  cmd,
	output stat_t                 stat
);

	localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int CW = (AW + 1 > 3) ? AW + 1 : 3;
	localparam logic [WORD_BITS-1:0] ONES = '1;

	function automatic logic [5:0] low_set(input logic [WORD_BITS-1:0] v);
		logic [2:0] k;
		logic [2:0] j;
		logic [7:0] b;
		k = '0;
		for (int i = 7; i >= 0; i--) if (|v[i*8 +: 8]) k = 3'(i);
		b = v[{k, 3'b000} +: 8];
		j = '0;
		for (int i = 7; i >= 0; i--) if (b[i]) j = 3'(i);
		return {k, j};
	endfunction

	function automatic logic [5:0] high_set(input logic [WORD_BITS-1:0] v);
		logic [2:0] k;
		logic [2:0] j;
		logic [7:0] b;
		k = '0;
		for (int i = 0; i < 8; i++) if (|v[i*8 +: 8]) k = 3'(i);
		b = v[{k, 3'b000} +: 8];
		j = '0;
		for (int i = 0; i < 8; i++) if (b[i]) j = 3'(i);
		return {k, j};
	endfunction

	logic [WORD_BITS-1:0] mem [MAP_WORDS];
	logic [MAP_WORDS-1:0] valid_q;

	logic [2:0]           block_count_q;
	logic [8:0]           installed_q;
	logic [2:0]           mode_q;
	logic [5:0]           bit_q;
	logic [AW-1:0]        ptr_q;
	logic                 first_q;
	logic                 wrap_q;
	logic [8:0]           left_q;
	logic [7:0]           res_idx_q;
	logic                 flag_q;
	logic [WORD_BITS-1:0] rd_data_q;
	logic                 rd_vld_q;
	logic                 out_valid_q;
	out_item_t            out_item_q;

	logic [2:0]           n;
	logic [2:0]           in_word;
	logic [2:0]           start;
	logic [CW-1:0]        ptr_ext;
	logic [CW-1:0]        n_ext;
	logic                 higher;
	logic                 last_dir;
	logic [WORD_BITS-1:0] word;
	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] masked;
	logic [5:0]           hit_bit;
	logic [WORD_BITS-1:0] bit_mask;
	logic [WORD_BITS-1:0] fill_word;
	logic [WORD_BITS-1:0] wdata;
	logic                 we;
	logic                 is_fill_mode;
	logic                 is_bit_mode;
	logic                 is_find_mode;

	// words in use, saturated to the store depth
	always_comb begin
		if (32'(block_count_q) > MAP_WORDS) n = 3'(MAP_WORDS);
		else                                n = block_count_q;
	end

	// start word of a search: seed word mod n
	always_comb begin
		in_word = {1'b0, in_item.cpu_index[7:6]};
		start   = in_word;
		for (int i = 0; i < 3; i++) if (start >= n) start = start - n;
	end

	assign is_bit_mode  = (in_item.mode == MODE_SET) || (in_item.mode == MODE_CLEAR) ||
	                      (in_item.mode == MODE_TEST);
	assign is_find_mode = (in_item.mode == MODE_FIND_HI) || (in_item.mode == MODE_FIND_LO);
	assign is_fill_mode = (in_item.mode == MODE_SET_ALL) || (in_item.mode == MODE_CLEAR_ALL);

	assign ptr_ext  = CW'(ptr_q);
	assign n_ext    = CW'(n);
	assign higher   = (mode_q == MODE_FIND_HI);
	assign last_dir = higher ? (ptr_ext + CW'(1) == n_ext) : (ptr_q == '0);

	assign word = rd_vld_q ? rd_data_q : '0;

	always_comb begin
		if (!first_q)    mask = ONES;
		else if (higher) mask = (ONES << bit_q) << 1;
		else             mask = (WORD_BITS'(1) << bit_q) - WORD_BITS'(1);
	end

	assign masked   = word & mask;
	assign hit_bit  = higher ? low_set(masked) : high_set(masked);
	assign bit_mask = WORD_BITS'(1) << bit_q;

	// fill word at the pointer: ones for cpus still left in set-all, zero in clear-all
	always_comb begin
		if (left_q >= 9'(WORD_BITS)) fill_word = ONES;
		else fill_word = (WORD_BITS'(1) << left_q[5:0]) - WORD_BITS'(1);
	end

	always_comb begin
		we    = 1'b0;
		wdata = fill_word;
		if (cmd.fill) begin
			we = 1'b1;
		end else if (cmd.bit_wr && mode_q == MODE_SET) begin
			we    = 1'b1;
			wdata = word | bit_mask;
		end else if (cmd.bit_wr && mode_q == MODE_CLEAR) begin
			we    = 1'b1;
			wdata = word & ~bit_mask;
		end
	end

	// bitmap store: one read port with registered data, one write port
	always_ff @(posedge clk) begin
		if (we) mem[ptr_q] <= wdata;
		if (cmd.rd) rd_data_q <= mem[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[ptr_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) rd_vld_q <= valid_q[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= BLOCK_COUNT_RST;
			installed_q   <= INSTALLED_CPUS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BLOCK_COUNT:    block_count_q <= cfg_data[2:0];
				REG_INSTALLED_CPUS: installed_q   <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// item registers and search pointer
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q    <= in_item.mode;
			bit_q     <= in_item.cpu_index[5:0];
			first_q   <= 1'b1;
			wrap_q    <= 1'b0;
			res_idx_q <= '0;
			flag_q    <= 1'b0;
			left_q    <= (in_item.mode == MODE_SET_ALL) ? installed_q : 9'd0;
			if (is_find_mode)      ptr_q <= AW'(start);
			else if (is_fill_mode) ptr_q <= '0;
			else                   ptr_q <= AW'(in_word);
		end else if (cmd.bit_wr) begin
			if (mode_q == MODE_TEST) flag_q <= word[bit_q];
		end else if (cmd.find_step) begin
			first_q <= 1'b0;
			if (|masked) begin
				res_idx_q <= {ptr_ext[1:0], hit_bit};
				flag_q    <= 1'b1;
			end else if (last_dir) begin
				if (!wrap_q) begin
					wrap_q <= 1'b1;
					ptr_q  <= higher ? '0 : AW'(n - 3'd1);
				end
			end else begin
				ptr_q <= higher ? ptr_q + AW'(1) : ptr_q - AW'(1);
			end
		end else if (cmd.fill) begin
			ptr_q  <= ptr_q + AW'(1);
			left_q <= (left_q >= 9'(WORD_BITS)) ? left_q - 9'(WORD_BITS) : 9'd0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			out_item_q.result_index <= res_idx_q;
			out_item_q.flag         <= flag_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	assign stat.go_bit    = is_bit_mode && (in_word < n);
	assign stat.go_find   = is_find_mode && (n != 3'd0);
	assign stat.go_fill   = is_fill_mode && (n != 3'd0);
	assign stat.hit       = |masked;
	assign stat.exhausted = !(|masked) && last_dir && wrap_q;
	assign stat.fill_last = (ptr_ext + CW'(1) == n_ext);
	assign stat.out_free  = !out_valid_q || out_ready;

	a_wr_in_map: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fill || cmd.bit_wr) |-> (ptr_ext < n_ext))
		else $error("bitmap access beyond the words in use");

	a_load_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (!flag_q && res_idx_q == 8'd0))
		else $error("result not cleared when an item is taken");

	a_hit_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.find_step && stat.hit) |=> flag_q)
		else $error("search hit not recorded");

	a_publish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> (!out_valid_q || out_ready))
		else $error("result overwrote an item not yet taken");

endmodule
